@@ hw/rtl/frsk_pkg.sv @@
package frsk_pkg;

  // command codes
  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_KICK_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KICK_DURATION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT        = 2'd2;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned ELAPSED_W  = 16;

  typedef logic [2:0] speed_t;

  localparam speed_t SPEED_OFF  = 3'd0;
  localparam speed_t SPEED_ONE  = 3'd1;
  localparam speed_t SPEED_TWO  = 3'd2;
  localparam speed_t SPEED_THREE = 3'd3;
  localparam speed_t SPEED_FULL = 3'd4;

  typedef struct packed {
    logic               command;
    logic signed [15:0] level;
  } in_item_t;

  typedef struct packed {
    logic       relay_one;
    logic       relay_two;
    logic       relay_three;
    logic [6:0] reported_level;
    logic       kick_running;
  } out_item_t;

  // clamp a signed percentage and quantize it to a speed
  function automatic speed_t speed_of_level(input logic signed [15:0] lv);
    speed_t s;
    if (lv <= 16'sd0) begin
      s = SPEED_OFF;
    end else if (lv <= 16'sd25) begin
      s = SPEED_ONE;
    end else if (lv <= 16'sd50) begin
      s = SPEED_TWO;
    end else if (lv <= 16'sd75) begin
      s = SPEED_THREE;
    end else begin
      s = SPEED_FULL;
    end
    return s;
  endfunction

  // relay pattern per speed, bit 0 is relay one
  function automatic logic [2:0] relay_of_speed(input speed_t s);
    logic [2:0] r;
    case (s)
      SPEED_ONE:   r = 3'b001;
      SPEED_TWO:   r = 3'b010;
      SPEED_THREE: r = 3'b011;
      SPEED_FULL:  r = 3'b100;
      default:     r = 3'b000;
    endcase
    return r;
  endfunction

  // percentage reported for a speed
  function automatic logic [6:0] pct_of_speed(input speed_t s);
    logic [6:0] p;
    case (s)
      SPEED_ONE:   p = 7'd25;
      SPEED_TWO:   p = 7'd50;
      SPEED_THREE: p = 7'd75;
      SPEED_FULL:  p = 7'd100;
      default:     p = 7'd0;
    endcase
    return p;
  endfunction

endpackage

@@ hw/rtl/fan_relay_speed_kickstart_core.sv @@
// Three-relay fan speed controller with optional kickstart.
// Input channel (in_valid/in_ready/in_data): each beat is either a set
// command carrying a signed percentage, or a one-millisecond tick.
// Output channel (out_valid/out_ready/out_data): exactly one result beat per
// input beat, in order: relay drive levels, reported percentage of the target
// speed and the kickstart flag.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
// index 0 kick enable, 1 kick duration in ticks, 2 output inversion; other
// indexes are dropped. Write only while no item is in flight.
// A beat accepted into the input register passes through the state update into
// the result register once that is free. Throughput is one beat per cycle while
// the receiver does not stall, since the state update between the input register
// and the result register is combinational.
// Reset clears the fan to off, stops any kickstart, clears the config and
// empties both registers. When the receiver stalls the result register holds
// and the input register keeps one more beat; in_ready drops once both are full.
module fan_relay_speed_kickstart_core
  import frsk_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic                 kick_enable;
  logic [ELAPSED_W-1:0] kick_duration_ms;
  logic                 invert_outputs;

  // controller state
  speed_t               applied_speed;
  speed_t               target_speed;
  logic                 kick_active;
  logic [ELAPSED_W-1:0] kick_elapsed;

  // input register
  logic     in_full;
  in_item_t in_reg;

  speed_t               applied_speed_next;
  speed_t               target_speed_next;
  logic                 kick_active_next;
  logic [ELAPSED_W-1:0] kick_elapsed_next;
  logic [ELAPSED_W-1:0] elapsed_inc;
  speed_t               want;
  logic                 start_kick;
  logic                 advance;
  logic [2:0]           relays;
  out_item_t            result;

  assign cfg_ready = 1'b1;
  assign advance   = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || advance;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      kick_enable      <= 1'b0;
      kick_duration_ms <= '0;
      invert_outputs   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KICK_ENABLE:   kick_enable      <= cfg_data[0];
        CFG_KICK_DURATION: kick_duration_ms <= cfg_data;
        CFG_INVERT:        invert_outputs   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_data;
    end
  end

  // state update for the buffered beat
  always_comb begin
    want        = speed_of_level(in_reg.level);
    start_kick  = kick_enable && (kick_duration_ms != '0) &&
                  (applied_speed == SPEED_OFF) &&
                  (want >= SPEED_ONE) && (want <= SPEED_THREE);
    elapsed_inc = (kick_elapsed == '1) ? kick_elapsed : kick_elapsed + 1'b1;

    applied_speed_next = applied_speed;
    target_speed_next  = target_speed;
    kick_active_next   = kick_active;
    kick_elapsed_next  = kick_elapsed;

    if (in_reg.command == CMD_SET) begin
      target_speed_next = want;
      if (start_kick) begin
        applied_speed_next = SPEED_FULL;
        kick_active_next   = 1'b1;
        kick_elapsed_next  = '0;
      end else begin
        applied_speed_next = want;
        kick_active_next   = 1'b0;
      end
    end else if (kick_active) begin
      kick_elapsed_next = elapsed_inc;
      if (elapsed_inc >= kick_duration_ms) begin
        applied_speed_next = target_speed;
        kick_active_next   = 1'b0;
      end
    end
  end

  // result built from the updated state
  always_comb begin
    relays                = relay_of_speed(applied_speed_next) ^ {3{invert_outputs}};
    result.relay_one      = relays[0];
    result.relay_two      = relays[1];
    result.relay_three    = relays[2];
    result.reported_level = pct_of_speed(target_speed_next);
    result.kick_running   = kick_active_next;
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      applied_speed <= SPEED_OFF;
      target_speed  <= SPEED_OFF;
      kick_active   <= 1'b0;
      kick_elapsed  <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (advance) begin
        applied_speed <= applied_speed_next;
        target_speed  <= target_speed_next;
        kick_active   <= kick_active_next;
        kick_elapsed  <= kick_elapsed_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

@@ hw/rtl/frsk_checker.sv @@
module frsk_checker
  import frsk_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // nothing shown right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // reported level is one of the five speed percentages
  a_level_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.reported_level == 7'd0 || out_data.reported_level == 7'd25 ||
                   out_data.reported_level == 7'd50 || out_data.reported_level == 7'd75 ||
                   out_data.reported_level == 7'd100))
    else $error("reported level outside speed table");

  // during kickstart relays show full speed, whatever the inversion
  a_kick_relays: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kick_running |->
      out_data.relay_one == out_data.relay_two &&
      out_data.relay_three != out_data.relay_one)
    else $error("kickstart without full speed pattern");

  // kickstart only heads for speeds one to three
  a_kick_target: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kick_running |->
      (out_data.reported_level == 7'd25 || out_data.reported_level == 7'd50 ||
       out_data.reported_level == 7'd75))
    else $error("kickstart with invalid target");

endmodule

bind fan_relay_speed_kickstart_core frsk_checker u_frsk_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
